FILE: design/kmrr_pkg.sv
// Package for the k-way merge rank resolver: word layouts, codes,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package kmrr_pkg;

   localparam int MAX_CHUNKS_DEF = 64;
   localparam int ESCAPE_DEF     = 255;
   localparam int RANK_BITS_DEF  = 40;

   localparam int CHUNK_W = 6;
   localparam int FIELD_W = 40;
   localparam int COUNT_W = 31;
   localparam int CSR_W   = 7;
   localparam logic [CSR_W-1:0] CHUNK_COUNT_RST = 7'd64;

   localparam logic [1:0] ACT_INSERT  = 2'd0;
   localparam logic [1:0] ACT_REPLACE = 2'd1;
   localparam logic [1:0] ACT_POP     = 2'd2;
   localparam logic [1:0] ACT_NOP     = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic [CHUNK_W-1:0] src_chunk;
      logic [FIELD_W-1:0] cur_rank;
      logic [FIELD_W-1:0] nxt_rank;
      logic [COUNT_W-1:0] run_count;
   } req_payload_type;

   typedef struct packed {
      logic               record_valid;
      logic [CHUNK_W-1:0] out_chunk;
      logic [FIELD_W-1:0] rank_value;
      logic [7:0]         run_byte;
      logic               last_result;
      logic               error;
      logic               heap_empty;
      logic [CHUNK_W-1:0] root_chunk;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UP,
      ST_POP_WAIT,
      ST_DOWN,
      ST_RESOLVE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       up_begin;
      logic       up_step;
      logic       take_replace;
      logic       take_pop;
      logic       pop_fetch;
      logic       dn_step;
      logic       resolve;
      logic       emit;
      logic [1:0] slot;
   } cmd_type;

   typedef struct packed {
      logic       ins_ok;
      logic       rep_ok;
      logic       pop_ok;
      logic       pop_last;
      logic       up_done;
      logic       dn_done;
      logic       out_free;
      logic [1:0] last_slot;
   } status_type;

endpackage

FILE: design/kmrr_if.sv
// Handshake channels of the merge rank resolver: request and response.
// Depends on kmrr_pkg for the payload types.
`timescale 1ns / 1ps

interface kmrr_req_if import kmrr_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface kmrr_rsp_if import kmrr_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/kmrr_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kmrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: design/kmrr_ctrl.sv
// Sequencer of the merge rank resolver: decode, sift up/down, resolve, emit.
// Depends on kmrr_pkg for states, command and status structs.
`timescale 1ns / 1ps

module kmrr_ctrl import kmrr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output cmd_type    cmd,
   input  status_type st
);

   state_type  state_ff, state_in;
   logic [1:0] slot_ff, slot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.slot  = slot_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (st.ins_ok) begin
               cmd.up_begin = 1'b1;
               state_in     = ST_UP;
            end else if (st.rep_ok) begin
               cmd.take_replace = 1'b1;
               state_in         = ST_DOWN;
            end else if (st.pop_ok) begin
               cmd.take_pop = 1'b1;
               state_in     = st.pop_last ? ST_RESOLVE : ST_POP_WAIT;
            end else begin
               state_in = ST_RESOLVE;
            end
         end
         ST_UP: begin
            cmd.up_step = 1'b1;
            if (st.up_done) state_in = ST_RESOLVE;
         end
         ST_POP_WAIT: begin
            // last entry arrives from the RAM, becomes the sinking item
            cmd.pop_fetch = 1'b1;
            state_in      = ST_DOWN;
         end
         ST_DOWN: begin
            cmd.dn_step = 1'b1;
            if (st.dn_done) state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            cmd.resolve = 1'b1;
            slot_in     = '0;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (slot_ff == st.last_slot) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in = slot_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: design/kmrr_dp.sv
// Datapath of the merge rank resolver: heap RAM, sift compare/move logic,
// rank resolution, result slots and output register. Uses kmrr_pkg, kmrr_ram.
`timescale 1ns / 1ps

module kmrr_dp import kmrr_pkg::*; #(
   parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
   parameter int ESCAPE     = ESCAPE_DEF,
   parameter int RANK_BITS  = RANK_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CSR_W-1:0]   csr_wr_data,
   input  req_payload_type    req_payload,
   output rsp_payload_type    rsp_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  cmd_type            cmd,
   output status_type         st
);

   localparam int AW   = $clog2(MAX_CHUNKS);
   localparam int SW   = $clog2(MAX_CHUNKS + 1);
   localparam int CIW  = AW + 2;
   localparam int CMPW = (SW > CSR_W) ? SW : CSR_W;

   typedef struct packed {
      logic [CHUNK_W-1:0]   chunk;
      logic [RANK_BITS-1:0] cur;
      logic [RANK_BITS-1:0] nxt;
      logic [COUNT_W-1:0]   cnt;
   } trip_type;

   typedef struct packed {
      logic               vld;
      logic [CHUNK_W-1:0] chunk;
      logic [FIELD_W-1:0] rank;
      logic [7:0]         cbyte;
   } slot_type;

   function automatic logic trip_gt(trip_type a, trip_type b);
      return {a.cur, a.nxt, a.chunk} > {b.cur, b.nxt, b.chunk};
   endfunction

   logic [1:0]           act_ff, act_in;
   trip_type             sup_ff, sup_in;
   logic                 err_ff, err_in;
   logic                 took_ff, took_in;
   logic [SW-1:0]        size_ff, size_in;
   logic [AW-1:0]        pos_ff, pos_in;
   trip_type             item_ff, item_in;
   trip_type             taken_ff, taken_in;
   trip_type             root_ff, root_in;
   logic [CSR_W-1:0]     cc_ff, cc_in;
   logic                 have_prev_ff, have_prev_in;
   trip_type             prev_ff, prev_in;
   logic [RANK_BITS-1:0] running_ff, running_in;
   logic [FIELD_W-1:0]   group_ff, group_in;
   slot_type             slot_ff [4];
   slot_type             slot_in [4];
   logic [2:0]           nslots_ff, nslots_in;
   rsp_payload_type      rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
   trip_type             wr_data, rda, rdb;

   kmrr_ram #(
      .WIDTH ($bits(trip_type)),
      .DEPTH (MAX_CHUNKS)
   ) u_heap (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rda),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rdb)
   );

   // sift neighborhood
   logic [AW-1:0]  parent_idx, gparent_idx;
   logic [CIW-1:0] c0, c1, sel_idx, nc0;
   logic           has0, has1, pick1, move_dn, move_up, full;
   trip_type       sel;

   always_comb begin
      parent_idx  = (pos_ff - AW'(1)) >> 1;
      gparent_idx = (parent_idx - AW'(1)) >> 1;
      c0          = (CIW'(pos_ff) << 1) + CIW'(1);
      c1          = c0 + CIW'(1);
      has0        = c0 < CIW'(size_ff);
      has1        = c1 < CIW'(size_ff);
      pick1       = has1 && trip_gt(rda, rdb);
      sel         = pick1 ? rdb : rda;
      sel_idx     = pick1 ? c1 : c0;
      nc0         = (sel_idx << 1) + CIW'(1);
      move_dn     = has0 && trip_gt(item_ff, sel);
      move_up     = (pos_ff != '0) && trip_gt(rda, item_ff);
      full        = (CMPW'(size_ff) >= CMPW'(cc_ff)) || (size_ff >= SW'(MAX_CHUNKS));
   end

   // rank resolution of the taken triplet against the previous one
   logic                 same_pair, rec_a, rec_b;
   logic [COUNT_W-1:0]   rc, lc;
   logic [RANK_BITS-1:0] rr_new;
   logic [FIELD_W-1:0]   gt_new;
   slot_type             sl [4];
   logic [2:0]           n;

   always_comb begin
      same_pair = (taken_ff.cur == prev_ff.cur) && (taken_ff.nxt == prev_ff.nxt);
      rc        = prev_ff.cnt;
      rr_new    = taken_ff.cur;
      gt_new    = FIELD_W'(taken_ff.cnt);
      if (have_prev_ff) begin
         if (same_pair) begin
            rr_new = running_ff;
            gt_new = group_ff + FIELD_W'(taken_ff.cnt);
         end else begin
            if (group_ff == FIELD_W'(1)) rc = '0;
            rr_new = (taken_ff.cur == prev_ff.cur) ?
                     running_ff + RANK_BITS'(group_ff) : taken_ff.cur;
         end
      end
      lc = taken_ff.cnt;
      if (taken_ff.cnt == COUNT_W'(1) && (!have_prev_ff || !same_pair)) lc = '0;
      rec_a = took_ff && have_prev_ff;
      rec_b = took_ff && (size_ff == '0);

      for (int i = 0; i < 4; i++) sl[i] = '0;
      n = '0;
      if (rec_a) begin
         sl[n[1:0]] = '{1'b1, prev_ff.chunk, FIELD_W'(running_ff),
                        (rc < COUNT_W'(ESCAPE)) ? rc[7:0] : 8'(ESCAPE)};
         if (rc >= COUNT_W'(ESCAPE)) begin
            sl[2'(n + 3'd1)] = '{1'b1, prev_ff.chunk, FIELD_W'(rc), 8'd0};
            n = n + 3'd2;
         end else begin
            n = n + 3'd1;
         end
      end
      if (rec_b) begin
         sl[n[1:0]] = '{1'b1, taken_ff.chunk, FIELD_W'(rr_new),
                        (lc < COUNT_W'(ESCAPE)) ? lc[7:0] : 8'(ESCAPE)};
         if (lc >= COUNT_W'(ESCAPE)) begin
            sl[2'(n + 3'd1)] = '{1'b1, taken_ff.chunk, FIELD_W'(lc), 8'd0};
            n = n + 3'd2;
         end else begin
            n = n + 3'd1;
         end
      end
      if (n == '0) n = 3'd1;
   end

   always_comb begin
      act_in       = act_ff;
      sup_in       = sup_ff;
      err_in       = err_ff;
      took_in      = took_ff;
      size_in      = size_ff;
      pos_in       = pos_ff;
      item_in      = item_ff;
      taken_in     = taken_ff;
      root_in      = root_ff;
      cc_in        = cc_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      running_in   = running_ff;
      group_in     = group_ff;
      slot_in      = slot_ff;
      nslots_in    = nslots_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = item_ff;
      rd_addr_a    = '0;
      rd_addr_b    = '0;

      if (csr_wr_en) cc_in = csr_wr_data;

      if (cmd.load) begin
         act_in  = req_payload.action;
         sup_in  = '{req_payload.src_chunk, RANK_BITS'(req_payload.cur_rank),
                     RANK_BITS'(req_payload.nxt_rank), req_payload.run_count};
         err_in  = ((req_payload.action == ACT_INSERT) && full) ||
                   ((req_payload.action == ACT_REPLACE || req_payload.action == ACT_POP) &&
                    (size_ff == '0));
         took_in = 1'b0;
      end

      if (cmd.up_begin) begin
         size_in   = size_ff + SW'(1);
         pos_in    = AW'(size_ff);
         item_in   = sup_ff;
         rd_addr_a = AW'((size_ff - SW'(1)) >> 1);
      end

      if (cmd.up_step) begin
         wr_en = 1'b1;
         if (move_up) begin
            wr_data   = rda;
            pos_in    = parent_idx;
            rd_addr_a = gparent_idx;
         end
      end

      if (cmd.take_replace) begin
         taken_in  = root_ff;
         took_in   = 1'b1;
         item_in   = sup_ff;
         pos_in    = '0;
         rd_addr_a = AW'(1);
         rd_addr_b = AW'(2);
      end

      if (cmd.take_pop) begin
         taken_in  = root_ff;
         took_in   = 1'b1;
         size_in   = size_ff - SW'(1);
         rd_addr_a = AW'(size_ff - SW'(1));
      end

      if (cmd.pop_fetch) begin
         item_in   = rda;
         pos_in    = '0;
         rd_addr_a = AW'(1);
         rd_addr_b = AW'(2);
      end

      if (cmd.dn_step) begin
         wr_en = 1'b1;
         if (move_dn) begin
            wr_data   = sel;
            pos_in    = AW'(sel_idx);
            rd_addr_a = AW'(nc0);
            rd_addr_b = AW'(nc0 + CIW'(1));
         end
      end

      if (wr_en && wr_addr == '0) root_in = wr_data;

      if (cmd.resolve) begin
         slot_in   = sl;
         nslots_in = n;
         if (took_ff) begin
            running_in   = rr_new;
            group_in     = gt_new;
            prev_in      = taken_ff;
            have_prev_in = size_ff != '0;
         end
      end

      if (cmd.emit) begin
         rsp_in.record_valid = slot_ff[cmd.slot].vld;
         rsp_in.out_chunk    = slot_ff[cmd.slot].chunk;
         rsp_in.rank_value   = slot_ff[cmd.slot].rank;
         rsp_in.run_byte     = slot_ff[cmd.slot].cbyte;
         rsp_in.last_result  = cmd.slot == st.last_slot;
         rsp_in.error        = err_ff;
         rsp_in.heap_empty   = size_ff == '0;
         rsp_in.root_chunk   = (size_ff == '0) ? '0 : root_ff.chunk;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         cc_ff        <= CHUNK_COUNT_RST;
         have_prev_ff <= 1'b0;
         prev_ff      <= '0;
         running_ff   <= '0;
         group_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         took_ff      <= 1'b0;
         err_ff       <= 1'b0;
         nslots_ff    <= 3'd1;
      end else begin
         size_ff      <= size_in;
         cc_ff        <= cc_in;
         have_prev_ff <= have_prev_in;
         prev_ff      <= prev_in;
         running_ff   <= running_in;
         group_ff     <= group_in;
         rsp_valid_ff <= rsp_valid_in;
         took_ff      <= took_in;
         err_ff       <= err_in;
         nslots_ff    <= nslots_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      sup_ff   <= sup_in;
      pos_ff   <= pos_in;
      item_ff  <= item_in;
      taken_ff <= taken_in;
      root_ff  <= root_in;
      slot_ff  <= slot_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      st.ins_ok    = (act_ff == ACT_INSERT) && !err_ff;
      st.rep_ok    = (act_ff == ACT_REPLACE) && !err_ff;
      st.pop_ok    = (act_ff == ACT_POP) && !err_ff;
      st.pop_last  = size_ff == SW'(1);
      st.up_done   = !move_up;
      st.dn_done   = !move_dn;
      st.out_free  = !rsp_valid_ff || rsp_ready;
      st.last_slot = 2'(nslots_ff - 3'd1);
   end

   assign rsp_payload = rsp_ff;
   assign rsp_valid   = rsp_valid_ff;

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= SW'(MAX_CHUNKS))
      else $error("heap size above capacity");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CIW'(wr_addr) < CIW'(size_ff))
      else $error("heap write outside live entries");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.up_begin |-> !full)
      else $error("insert started on a full heap");

   a_slots_after_resolve: assert property (@(posedge clock) disable iff (reset)
      cmd.resolve |=> (nslots_ff != '0) && (nslots_ff <= 3'd4))
      else $error("bad result slot count");

endmodule

FILE: design/kway_merge_rank_resolver.sv
// Channel | dir | word                                | handshake
// req_if  | in  | action, chunk, ranks, run count     | valid/ready
// rsp_if  | out | record, status after the step       | valid/ready
// csr     | in  | chunk_count (7 bits)                | csr_wr_en strobe
//
// Per word: accept, decode, sift, resolve, then emit each result in turn.
// Sift is one heap level per cycle against the two-read-port heap RAM:
// insert sifts up; replace sifts down; pop fetches the last entry and sifts it down.
// Results wait while rsp_if is not ready; a new word is taken only once all are out.
// Reset (synchronous) empties the heap; heap RAM is not cleared.
// Top level; depends on kmrr_pkg, kmrr_if, kmrr_ctrl, kmrr_dp, kmrr_ram.
`timescale 1ns / 1ps

module kway_merge_rank_resolver import kmrr_pkg::*; #(
   parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
   parameter int ESCAPE     = ESCAPE_DEF,
   parameter int RANK_BITS  = RANK_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data,
   kmrr_req_if.sink         req_if,
   kmrr_rsp_if.source       rsp_if
);

   cmd_type    cmd;
   status_type st;

   kmrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .st        (st)
   );

   kmrr_dp #(
      .MAX_CHUNKS (MAX_CHUNKS),
      .ESCAPE     (ESCAPE),
      .RANK_BITS  (RANK_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_if.payload),
      .rsp_payload (rsp_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .cmd         (cmd),
      .st          (st)
   );

endmodule

FILE: sim/tb_kway_merge_rank_resolver.sv
// Self-checking bench for kway_merge_rank_resolver: drives heap actions, predicts
// merge records with a behavioral heap, checks every response word.
// Depends on kmrr_pkg, kmrr_if and the design sources.
`timescale 1ns / 1ps

module tb_kway_merge_rank_resolver;
   import kmrr_pkg::*;

   localparam int ESC       = ESCAPE_DEF;
   localparam int HEAP_MAX  = MAX_CHUNKS_DEF;
   localparam int STALL_CYC = 400;
   localparam int WDOG_MAX  = 3000;
   localparam logic [FIELD_W-1:0] RMASK = {FIELD_W{1'b1}};

   typedef struct packed {
      logic [CHUNK_W-1:0] chunk;
      logic [FIELD_W-1:0] cur;
      logic [FIELD_W-1:0] nxt;
      logic [COUNT_W-1:0] cnt;
   } triplet_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   kmrr_req_if req_if ();
   kmrr_rsp_if rsp_if ();

   kway_merge_rank_resolver uut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_if(req_if), .rsp_if(rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // prediction state
   triplet_type     heap_q [HEAP_MAX];
   int              heap_n;
   int              chunk_cap;
   bit              have_prev;
   triplet_type     prev_trip;
   logic [FIELD_W-1:0] run_rank;
   logic [FIELD_W-1:0] grp_total;

   rsp_payload_type expected_words [$];
   req_payload_type pending_words [$];
   int  mismatches = 0;
   int  words_checked = 0;
   int  records_seen = 0;
   int  escapes_seen = 0;
   bit  hold_rsp = 1'b0;
   bit  pause_req = 1'b0;

   function automatic int trip_order(triplet_type a, triplet_type b);
      if (a.cur != b.cur) return a.cur < b.cur ? -1 : 1;
      if (a.nxt != b.nxt) return a.nxt < b.nxt ? -1 : 1;
      if (a.chunk != b.chunk) return a.chunk < b.chunk ? -1 : 1;
      return 0;
   endfunction

   task automatic heap_sift_down(triplet_type item);
      int parent, child;
      parent = 0;
      forever begin
         child = 2 * parent + 1;
         if (child >= heap_n) break;
         if (child + 1 < heap_n && trip_order(heap_q[child], heap_q[child+1]) > 0)
            child++;
         if (trip_order(item, heap_q[child]) > 0) begin
            heap_q[parent] = heap_q[child];
            parent = child;
         end else begin
            break;
         end
      end
      heap_q[parent] = item;
   endtask

   task automatic heap_sift_up(triplet_type item);
      int child, parent;
      child = heap_n;
      heap_n++;
      while (child > 0) begin
         parent = (child - 1) / 2;
         if (trip_order(heap_q[parent], item) > 0) begin
            heap_q[child] = heap_q[parent];
            child = parent;
         end else begin
            break;
         end
      end
      heap_q[child] = item;
   endtask

   task automatic push_record(ref rsp_payload_type recs [$], input logic [CHUNK_W-1:0] ch,
                              input logic [FIELD_W-1:0] rank, input logic [COUNT_W-1:0] cnt);
      rsp_payload_type r;
      r = '0;
      r.record_valid = 1'b1;
      r.out_chunk = ch;
      r.rank_value = rank;
      if (cnt < ESC) begin
         r.run_byte = cnt[7:0];
         recs.push_back(r);
      end else begin
         r.run_byte = 8'(ESC);
         recs.push_back(r);
         r.rank_value = FIELD_W'(cnt);
         r.run_byte = '0;
         recs.push_back(r);
      end
   endtask

   // merge step: updates heap and rank state, queues the expected words
   task automatic predict_merge_step(req_payload_type w);
      rsp_payload_type recs [$];
      rsp_payload_type r;
      triplet_type sup, taken;
      logic [COUNT_W-1:0] rc, lc;
      logic [FIELD_W-1:0] rr;
      bit err;
      err = 1'b0;
      sup = '{w.src_chunk, w.cur_rank, w.nxt_rank, w.run_count};
      if (w.action == ACT_INSERT) begin
         if (heap_n >= chunk_cap) err = 1'b1;
         else heap_sift_up(sup);
      end else if (w.action == ACT_REPLACE || w.action == ACT_POP) begin
         if (heap_n == 0) begin
            err = 1'b1;
         end else begin
            taken = heap_q[0];
            if (!have_prev) begin
               run_rank = taken.cur;
               grp_total = '0;
            end
            if (w.action == ACT_REPLACE) begin
               heap_sift_down(sup);
            end else begin
               heap_n--;
               if (heap_n > 0) heap_sift_down(heap_q[heap_n]);
            end
            if (!have_prev) begin
               grp_total = FIELD_W'(taken.cnt);
            end else begin
               rc = prev_trip.cnt;
               rr = run_rank;
               if (taken.cur == prev_trip.cur && taken.nxt == prev_trip.nxt) begin
                  grp_total = grp_total + FIELD_W'(taken.cnt);
               end else begin
                  if (grp_total == 1) rc = '0;
                  if (taken.cur == prev_trip.cur) run_rank = (run_rank + grp_total) & RMASK;
                  else run_rank = taken.cur;
                  grp_total = FIELD_W'(taken.cnt);
               end
               push_record(recs, prev_trip.chunk, rr, rc);
            end
            if (heap_n == 0) begin
               lc = taken.cnt;
               if (taken.cnt == 1 && (!have_prev || taken.cur != prev_trip.cur ||
                                      taken.nxt != prev_trip.nxt))
                  lc = '0;
               push_record(recs, taken.chunk, run_rank, lc);
            end
            prev_trip = taken;
            have_prev = heap_n != 0;
         end
      end
      if (recs.size() == 0) recs.push_back('0);
      foreach (recs[i]) begin
         r = recs[i];
         r.last_result = (i == recs.size() - 1);
         r.error = err;
         r.heap_empty = (heap_n == 0);
         r.root_chunk = heap_n == 0 ? '0 : heap_q[0].chunk;
         expected_words.push_back(r);
      end
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("MISMATCH word %0d %s: got %0h expected %0h", words_checked, what, got, want);
   endtask

   // driver: a word is predicted at the edge where it is accepted
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap <= 0;
      end else if (req_if.valid && !req_if.ready) begin
         // hold
      end else begin
         if (req_if.valid) begin
            predict_merge_step(req_if.payload);
            void'(pending_words.pop_front());
         end
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_words.size() != 0 && !pause_req) begin
            req_if.valid <= 1'b1;
            req_if.payload <= pending_words[0];
            req_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor / receiver
   int rsp_gap = 0;
   always @(posedge clock) begin
      rsp_payload_type want, got;
      int gap;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", 64'(got), 64'd0);
            end else begin
               want = expected_words.pop_front();
               if (got.record_valid !== want.record_valid)
                  report_mismatch("record_valid", 64'(got.record_valid),
                                  64'(want.record_valid));
               if (got.out_chunk !== want.out_chunk)
                  report_mismatch("out_chunk", 64'(got.out_chunk), 64'(want.out_chunk));
               if (got.rank_value !== want.rank_value)
                  report_mismatch("rank_value", 64'(got.rank_value), 64'(want.rank_value));
               if (got.run_byte !== want.run_byte)
                  report_mismatch("run_byte", 64'(got.run_byte), 64'(want.run_byte));
               if (got.last_result !== want.last_result)
                  report_mismatch("last_result", 64'(got.last_result),
                                  64'(want.last_result));
               if (got.error !== want.error)
                  report_mismatch("error", 64'(got.error), 64'(want.error));
               if (got.heap_empty !== want.heap_empty)
                  report_mismatch("heap_empty", 64'(got.heap_empty), 64'(want.heap_empty));
               if (got.root_chunk !== want.root_chunk)
                  report_mismatch("root_chunk", 64'(got.root_chunk), 64'(want.root_chunk));
               if (want.record_valid) records_seen++;
               if (want.record_valid && want.run_byte == ESC) escapes_seen++;
            end
            words_checked++;
         end
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
         end else if (rsp_if.valid && rsp_if.ready) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            rsp_gap <= gap;
            rsp_if.ready <= (gap == 0);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog on stalled progress
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || hold_rsp
          || (pending_words.size() == 0 && expected_words.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("timeout: %0d words pending, %0d expected", pending_words.size(),
                  expected_words.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_payload_type make_word(logic [1:0] act, logic [CHUNK_W-1:0] ch,
                                                 logic [FIELD_W-1:0] cr, logic [FIELD_W-1:0] nr,
                                                 logic [COUNT_W-1:0] cnt);
      req_payload_type w;
      w.action = act;
      w.src_chunk = ch;
      w.cur_rank = cr;
      w.nxt_rank = nr;
      w.run_count = cnt;
      return w;
   endfunction

   function automatic logic [FIELD_W-1:0] rand_rank(int span);
      if (span == 0) return FIELD_W'({$urandom, $urandom});
      return FIELD_W'($urandom_range(0, span));
   endfunction

   function automatic logic [COUNT_W-1:0] rand_count();
      case ($urandom_range(0, 5))
         0: return COUNT_W'(1);
         1: return COUNT_W'($urandom_range(ESC - 2, ESC + 2));
         2: return COUNT_W'($urandom) ;
         default: return COUNT_W'($urandom_range(0, 20));
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_if.valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_chunk_count(logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      chunk_cap = value > HEAP_MAX ? HEAP_MAX : int'(value);
   endtask

   // one merge: fill heap with k chunks, then replace/pop until empty
   task automatic queue_merge(int k, int span, int steps);
      for (int i = 0; i < k; i++)
         pending_words.push_back(make_word(ACT_INSERT, CHUNK_W'($urandom),
                                 rand_rank(span), rand_rank(span), rand_count()));
      for (int i = 0; i < steps; i++)
         pending_words.push_back(make_word(ACT_REPLACE, CHUNK_W'($urandom),
                                 rand_rank(span), rand_rank(span), rand_count()));
      for (int i = 0; i < k; i++)
         pending_words.push_back(make_word(ACT_POP, CHUNK_W'($urandom), '0, '0, '0));
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      heap_n = 0;
      chunk_cap = CHUNK_COUNT_RST;
      have_prev = 1'b0;
      prev_trip = '0;
      run_rank = '0;
      grp_total = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty takes, extremes, ties, escape counts, no-op action
      write_chunk_count(7'd2);
      pending_words.push_back(make_word(ACT_POP, '0, '0, '0, '0));
      pending_words.push_back(make_word(ACT_REPLACE, '1, RMASK, RMASK, '1));
      pending_words.push_back(make_word(ACT_NOP, '1, RMASK, '0, '1));
      pending_words.push_back(make_word(ACT_INSERT, 6'd63, RMASK, RMASK, '1));
      pending_words.push_back(make_word(ACT_INSERT, 6'd0, '0, '0, 31'd1));
      pending_words.push_back(make_word(ACT_INSERT, 6'd5, '0, '0, 31'd1));
      pending_words.push_back(make_word(ACT_REPLACE, 6'd7, '0, '0, 31'd1));
      pending_words.push_back(make_word(ACT_REPLACE, 6'd9, '0, 40'd3, 31'd254));
      pending_words.push_back(make_word(ACT_REPLACE, 6'd9, 40'd8, 40'd3, 31'd255));
      pending_words.push_back(make_word(ACT_POP, '0, '0, '0, '0));
      pending_words.push_back(make_word(ACT_POP, '0, '0, '0, '0));
      pending_words.push_back(make_word(ACT_INSERT, 6'd2, 40'd4, '0, 31'd1));
      pending_words.push_back(make_word(ACT_POP, '0, '0, '0, '0));
      pending_words.push_back(make_word(ACT_INSERT, 6'd3, RMASK, RMASK, '1));
      pending_words.push_back(make_word(ACT_POP, '0, '0, '0, '0));
      wait_drained();
      write_chunk_count(7'd0);
      pending_words.push_back(make_word(ACT_INSERT, 6'd1, 40'd1, 40'd1, 31'd1));
      pending_words.push_back(make_word(ACT_POP, '0, '0, '0, '0));
      wait_drained();

      // long receiver hold-off while the sender keeps offering words
      write_chunk_count(7'd127);
      queue_merge(8, 6, 4);
      hold_rsp = 1'b1;
      repeat (STALL_CYC) @(posedge clock);
      hold_rsp = 1'b0;
      wait_drained();

      // random merges at several chunk counts, small rank spans force ties
      for (int m = 0; m < 10; m++) begin
         write_chunk_count(m == 9 ? 7'd64 : CSR_W'($urandom_range(1, 10)));
         queue_merge(m == 9 ? $urandom_range(12, 20) : $urandom_range(1, chunk_cap),
                     m % 3 == 0 ? 0 : $urandom_range(2, 8), $urandom_range(0, 6));
         // noise: a no-op and a pop on the emptied heap
         if (m % 4 == 1) begin
            pending_words.push_back(make_word(ACT_NOP, CHUNK_W'($urandom), rand_rank(0),
                                    rand_rank(0), COUNT_W'($urandom)));
            pending_words.push_back(make_word(ACT_POP, '0, '0, '0, '0));
         end
         if (m == 5) begin
            // sender pauses mid-merge until every expected word has come back
            while (pending_words.size() > 2) @(posedge clock);
            pause_req = 1'b1;
            @(posedge clock);
            while (req_if.valid || expected_words.size() != 0) @(posedge clock);
            repeat (10) @(posedge clock);
            pause_req = 1'b0;
         end
         wait_drained();
      end
      wait_drained();

      $display("checked %0d response words, %0d records, %0d escape pairs",
               words_checked, records_seen, escapes_seen);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
